// ===== design/bounded_sequence_list_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded sequence list engine.
// Clocked, reset-qualified property wrappers used by bsle_ctrl.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SEQUENCE_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_SEQUENCE_LIST_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSLE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bsle_pkg.sv =====
// ----------------------------------------------------------------------------
// bsle_pkg
// Shared widths, command and status codes, and the cell command type.
// ----------------------------------------------------------------------------
`default_nettype none

package bsle_pkg;

    localparam int BSLE_DEPTH_DEFAULT = 64;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FPOS_W   = 7;
    localparam int COUNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_APPEND       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PREPEND      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND         = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE_LAST  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE_FIRST = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

    localparam logic [FPOS_W-1:0] FOUND_NONE = 7'h7F;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic signed [VALUE_W-1:0]  value;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== design/bsle_cell.sv =====
// ----------------------------------------------------------------------------
// bsle_cell
// One storage cell of the list. It holds, takes the word of its lower
// neighbor to open a gap, loads the new word, or takes its upper neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module bsle_cell
    import bsle_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  wire                         aclk,
    input  cell_cmd_t                   cell_cmd,
    input  wire  [CNT_W-1:0]            cell_pos,
    input  wire  signed [VALUE_W-1:0]   left_data,
    input  wire  signed [VALUE_W-1:0]   right_data,
    output logic signed [VALUE_W-1:0]   data
);

    localparam logic [CNT_W-1:0] IDX_V = CNT_W'(IDX);

    logic signed [VALUE_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        case (cell_cmd.op)
            CELL_INSERT: begin
                if (IDX_V == cell_pos) begin
                    data_reg <= cell_cmd.value;
                end else if (IDX_V > cell_pos) begin
                    data_reg <= left_data;
                end
            end
            CELL_SHIFT: begin
                data_reg <= right_data;
            end
            default: begin
            end
        endcase
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== design/bsle_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsle_ctrl
// Command sequencer: keeps the count, drives the cell row, runs the find
// scan over the rotating ring and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_sequence_list_engine_assert.svh"

module bsle_ctrl
    import bsle_pkg::*;
#(
    parameter int DEPTH = BSLE_DEPTH_DEFAULT,
    parameter int CNT_W = $clog2(DEPTH + 1),
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire  [CMD_W-1:0]            s_cmd,
    input  wire  [POS_W-1:0]            s_position,
    input  wire  signed [VALUE_W-1:0]   s_value,
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic [STATUS_W-1:0]         m_status,
    output logic signed [FPOS_W-1:0]    m_found_position,
    output logic [COUNT_W-1:0]          m_count,
    input  wire  signed [VALUE_W-1:0]   head_data,
    output cell_cmd_t                   cell_cmd,
    output logic [CNT_W-1:0]            cell_pos
);

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [CNT_W-1:0] DEPTH_V  = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [1:0]                 state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDX_W-1:0]           scan_idx_reg, scan_idx_next;
    logic signed [VALUE_W-1:0]  key_reg, key_next;
    logic                       hit_reg, hit_next;
    logic [FPOS_W-1:0]          found_reg, found_next;
    logic                       m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]        m_status_reg, m_status_next;
    logic [FPOS_W-1:0]          m_found_reg, m_found_next;
    logic [COUNT_W-1:0]         m_count_reg, m_count_next;

    logic                       accept;
    logic [CMP_W-1:0]           count_ext;
    logic [CMP_W-1:0]           count_next_ext;
    logic [CMP_W-1:0]           scan_ext;
    logic [CMP_W-1:0]           ins_pos;
    logic [STATUS_W-1:0]        res_status;

    assign s_ready        = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept         = s_valid && s_ready;
    assign count_ext      = CMP_W'(count_reg);
    assign count_next_ext = CMP_W'(count_next);
    assign scan_ext       = CMP_W'(scan_idx_reg);

    always_comb begin
        case (s_cmd)
            CMD_APPEND: begin
                ins_pos = count_ext;
            end
            CMD_PREPEND: begin
                ins_pos = '0;
            end
            default: begin
                ins_pos = CMP_W'(s_position);
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        key_next       = key_reg;
        hit_next       = hit_reg;
        found_next     = found_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_found_next   = m_found_reg;
        m_count_next   = m_count_reg;
        res_status     = STATUS_OK;
        cell_cmd.op    = CELL_HOLD;
        cell_cmd.value = s_value;
        cell_pos       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_cmd)
                        CMD_APPEND, CMD_PREPEND, CMD_INSERT: begin
                            if (ins_pos > count_ext) begin
                                res_status = STATUS_BADPOS;
                            end else if (count_reg == DEPTH_V) begin
                                res_status = STATUS_FULL;
                            end else begin
                                cell_cmd.op = CELL_INSERT;
                                cell_pos    = ins_pos[CNT_W-1:0];
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        CMD_REMOVE_LAST: begin
                            if (count_reg == '0) begin
                                res_status = STATUS_EMPTY;
                            end else begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        CMD_REMOVE_FIRST: begin
                            if (count_reg == '0) begin
                                res_status = STATUS_EMPTY;
                            end else begin
                                cell_cmd.op = CELL_SHIFT;
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (s_cmd == CMD_FIND) begin
                        key_next      = s_value;
                        scan_idx_next = '0;
                        hit_next      = 1'b0;
                        found_next    = FOUND_NONE;
                        state_next    = ST_SCAN;
                    end else begin
                        m_valid_next  = 1'b1;
                        m_status_next = res_status;
                        m_found_next  = FOUND_NONE;
                        m_count_next  = count_next_ext[COUNT_W-1:0];
                    end
                end
            end
            ST_SCAN: begin
                // The ring turns once; cell zero shows entry scan_idx_reg each cycle.
                cell_cmd.op = CELL_SHIFT;
                if (!hit_reg && (scan_ext < count_ext) && (head_data == key_reg)) begin
                    hit_next   = 1'b1;
                    found_next = scan_ext[FPOS_W-1:0];
                end
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = STATUS_OK;
                    m_found_next  = found_reg;
                    m_count_next  = count_ext[COUNT_W-1:0];
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            hit_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            hit_reg      <= hit_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        found_reg    <= found_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_count_reg  <= m_count_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_position = m_found_reg;
    assign m_count          = m_count_reg;

    `BSLE_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= DEPTH_V, "count above depth")
    `BSLE_ASSERT_NEXT(a_count_held, aclk, aresetn, !accept, $stable(count_reg), "count moved idle")
    `BSLE_ASSERT_SAME(a_scan_rotates, aclk, aresetn, state_reg == ST_SCAN, cell_cmd.op == CELL_SHIFT, "scan without rotation")
    `BSLE_ASSERT_NEXT(a_find_scans, aclk, aresetn, accept && (s_cmd == CMD_FIND), state_reg == ST_SCAN, "find did not scan")
    `BSLE_ASSERT_NEXT(a_scan_ends, aclk, aresetn, (state_reg == ST_SCAN) && (scan_idx_reg == LAST_IDX), state_reg == ST_DONE, "scan did not end")

endmodule

`default_nettype wire

// ===== design/bounded_sequence_list_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_sequence_list_engine
// Ordered list of up to DEPTH signed 32-bit words kept in a row of cells.
// ----------------------------------------------------------------------------
// Append, prepend, insert and both removals act on all cells in parallel:
// each cell holds, moves its word to a neighbor or loads the new word, and
// the result word is registered on the same edge. A find occupies the block
// while the whole ring of cells turns once past the single comparator at
// cell zero, which also restores the original order. A new command is
// taken whenever the sequencer is idle and the result register is free or
// being read. Cell contents need no clearing after reset.
`default_nettype none

module bounded_sequence_list_engine
    import bsle_pkg::*;
#(
    parameter int DEPTH = BSLE_DEPTH_DEFAULT
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire  [CMD_W-1:0]            s_cmd,
    input  wire  [POS_W-1:0]            s_position,
    input  wire  signed [VALUE_W-1:0]   s_value,
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic [STATUS_W-1:0]         m_status,
    output logic signed [FPOS_W-1:0]    m_found_position,
    output logic [COUNT_W-1:0]          m_count
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    cell_cmd_t                  cell_cmd;
    logic [CNT_W-1:0]           cell_pos;
    logic signed [VALUE_W-1:0]  cell_data [DEPTH];

    bsle_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_position       (s_position),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_found_position (m_found_position),
        .m_count          (m_count),
        .head_data        (cell_data[0]),
        .cell_cmd         (cell_cmd),
        .cell_pos         (cell_pos)
    );

    // The top cell takes cell zero on a shift, closing the ring for the scan.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_first
            bsle_cell #(
                .IDX   (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk       (aclk),
                .cell_cmd   (cell_cmd),
                .cell_pos   (cell_pos),
                .left_data  ('0),
                .right_data (cell_data[(i + 1) % DEPTH]),
                .data       (cell_data[i])
            );
        end else begin : g_rest
            bsle_cell #(
                .IDX   (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk       (aclk),
                .cell_cmd   (cell_cmd),
                .cell_pos   (cell_pos),
                .left_data  (cell_data[i - 1]),
                .right_data (cell_data[(i + 1) % DEPTH]),
                .data       (cell_data[i])
            );
        end
    end

endmodule

`default_nettype wire
